// File: design/r2dt_pkg.sv
// Shared constants, codes and tables for the 2D rigid transform core.
package r2dt_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int STEPS_MAX        = 24;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd2;

    localparam logic [2:0] FUNC_POINT_FWD = 3'd0;
    localparam logic [2:0] FUNC_DIR_FWD   = 3'd1;
    localparam logic [2:0] FUNC_POINT_INV = 3'd2;
    localparam logic [2:0] FUNC_ANGLE_ADD = 3'd3;
    localparam logic [2:0] FUNC_ANGLE_SUB = 3'd4;

    // Q30 angle constants, 36 bit signed, and the Q30 CORDIC gain, 33 bit signed
    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [32:0] Q30_GAIN    = 33'sd652032874;

    localparam logic signed [17:0] COS_RESET = 18'sd65536;
    localparam logic signed [17:0] SIN_RESET = 18'sd0;

    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] v;
        unique case (idx)
            5'd0:    v = 31'd843314857;
            5'd1:    v = 31'd497837830;
            5'd2:    v = 31'd263043837;
            5'd3:    v = 31'd133525159;
            5'd4:    v = 31'd67021687;
            5'd5:    v = 31'd33543516;
            5'd6:    v = 31'd16775851;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194283;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048576;
            5'd11:   v = 31'd524288;
            5'd12:   v = 31'd262144;
            5'd13:   v = 31'd131072;
            5'd14:   v = 31'd65536;
            5'd15:   v = 31'd32768;
            5'd16:   v = 31'd16384;
            5'd17:   v = 31'd8192;
            5'd18:   v = 31'd4096;
            5'd19:   v = 31'd2048;
            5'd20:   v = 31'd1024;
            5'd21:   v = 31'd512;
            5'd22:   v = 31'd256;
            5'd23:   v = 31'd128;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat38_32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v[37:31] == 7'b0000000 || v[37:31] == 7'b1111111) begin
            r = v[31:0];
        end else if (v[37]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat17_16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v[16] == v[15]) begin
            r = v[15:0];
        end else if (v[16]) begin
            r = 16'sh8000;
        end else begin
            r = 16'sh7fff;
        end
        return r;
    endfunction

    function automatic logic signed [17:0] sat19_18(input logic signed [18:0] v);
        logic signed [17:0] r;
        if (v[18] == v[17]) begin
            r = v[17:0];
        end else if (v[18]) begin
            r = 18'sh20000;
        end else begin
            r = 18'sh1ffff;
        end
        return r;
    endfunction

endpackage

// File: design/rigid_2d_transform_core.sv
// Top level of the 2D rigid transform core: config, CORDIC unit and datapath.
//
// Usage:
//  - Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) writes
//    angle (index 0, Q4.12), offset_x (1) and offset_y (2, Q16.16). Other
//    indexes are dropped. Write only while no word is in flight.
//  - An angle write starts the CORDIC unit, which updates cos/sin through its
//    wrap, half, iterate, negate and round states, one rotation step per cycle.
//    During that time both o_ready and o_cfg_ready are low.
//  - Input channel (i_valid/o_ready) takes func, x, y and angle words; output
//    channel (o_valid/i_ready) returns one result word per input word.
//  - Each word passes an input register, then the multiply, round,
//    offset and saturate logic into the result register.
//  - Throughput is one word per cycle while i_ready is high and the CORDIC unit is idle.
//  - When the receiver stalls, the result register and the input register
//    both hold; o_ready drops once both are full.
//  - Reset clears the config registers to zero, cos to one and sin to zero.
module rigid_2d_transform_core #(
    parameter int CORDIC_STEPS = r2dt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [r2dt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [r2dt_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_func,
    input  logic signed [31:0]                i_in_x,
    input  logic signed [31:0]                i_in_y,
    input  logic signed [15:0]                i_in_angle,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [31:0]                o_out_x,
    output logic signed [31:0]                o_out_y,
    output logic signed [15:0]                o_out_angle
);

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_HALF,
        S_ITER,
        S_NEG,
        S_ROUND
    } t_cordic_state;

    // config and trig state
    t_cordic_state      r_state;
    logic signed [15:0] r_angle;
    logic signed [31:0] r_offset_x;
    logic signed [31:0] r_offset_y;
    logic signed [17:0] r_cos;
    logic signed [17:0] r_sin;
    logic signed [35:0] r_z;
    logic signed [32:0] r_cx;
    logic signed [32:0] r_cy;
    logic               r_neg;
    logic [STEP_W-1:0]  r_step;

    logic               busy;
    logic               cfg_fire;
    logic signed [32:0] sh_x;
    logic signed [32:0] sh_y;
    logic signed [35:0] atan_step;
    logic signed [32:0] rnd_x;
    logic signed [32:0] rnd_y;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = i_rst_n && !busy;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    assign sh_x      = r_cx >>> r_step;
    assign sh_y      = r_cy >>> r_step;
    assign atan_step = $signed({5'b00000, r2dt_pkg::atan_q30(5'(r_step))});
    assign rnd_x     = r_cx + 33'sd8192;
    assign rnd_y     = r_cy + 33'sd8192;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_angle    <= '0;
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_cos      <= r2dt_pkg::COS_RESET;
            r_sin      <= r2dt_pkg::SIN_RESET;
            r_neg      <= 1'b0;
            r_step     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (cfg_fire) begin
                        unique case (i_cfg_index)
                            r2dt_pkg::REG_ANGLE: begin
                                r_angle <= i_cfg_data[15:0];
                                r_z     <= {{2{i_cfg_data[15]}}, i_cfg_data[15:0], 18'b0};
                                r_state <= S_WRAP;
                            end
                            r2dt_pkg::REG_OFFSET_X: r_offset_x <= i_cfg_data;
                            r2dt_pkg::REG_OFFSET_Y: r_offset_y <= i_cfg_data;
                            default: ;
                        endcase
                    end
                end
                S_WRAP: begin
                    priority if (r_z > r2dt_pkg::Q30_PI) begin
                        r_z <= r_z - r2dt_pkg::Q30_TWO_PI;
                    end else if (r_z < -r2dt_pkg::Q30_PI) begin
                        r_z <= r_z + r2dt_pkg::Q30_TWO_PI;
                    end else begin
                        r_z <= r_z;
                    end
                    r_state <= S_HALF;
                end
                S_HALF: begin
                    priority if (r_z > r2dt_pkg::Q30_HALF_PI) begin
                        r_z   <= r_z - r2dt_pkg::Q30_PI;
                        r_neg <= 1'b1;
                    end else if (r_z < -r2dt_pkg::Q30_HALF_PI) begin
                        r_z   <= r_z + r2dt_pkg::Q30_PI;
                        r_neg <= 1'b1;
                    end else begin
                        r_neg <= 1'b0;
                    end
                    r_cx    <= r2dt_pkg::Q30_GAIN;
                    r_cy    <= '0;
                    r_step  <= '0;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (!r_z[35]) begin
                        r_cx <= r_cx - sh_y;
                        r_cy <= r_cy + sh_x;
                        r_z  <= r_z - atan_step;
                    end else begin
                        r_cx <= r_cx + sh_y;
                        r_cy <= r_cy - sh_x;
                        r_z  <= r_z + atan_step;
                    end
                    if (r_step == LAST_STEP) begin
                        r_state <= S_NEG;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_NEG: begin
                    if (r_neg) begin
                        r_cx <= -r_cx;
                        r_cy <= -r_cy;
                    end
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_cos   <= r2dt_pkg::sat19_18(rnd_x[32:14]);
                    r_sin   <= r2dt_pkg::sat19_18(rnd_y[32:14]);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath: input register, then result register
    logic               r_a_valid;
    logic [2:0]         r_a_func;
    logic signed [31:0] r_a_x;
    logic signed [31:0] r_a_y;
    logic signed [15:0] r_a_angle;
    logic               r_b_valid;
    logic signed [31:0] r_b_x;
    logic signed [31:0] r_b_y;
    logic signed [15:0] r_b_angle;

    logic               adv_b;
    logic               adv_a;
    logic               is_inv;
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [18:0] c_e;
    logic signed [18:0] s_e;
    logic signed [51:0] p_ca;
    logic signed [51:0] p_sb;
    logic signed [51:0] p_sa;
    logic signed [51:0] p_cb;
    logic signed [52:0] sum_x;
    logic signed [52:0] sum_y;
    logic signed [36:0] rd_x;
    logic signed [36:0] rd_y;
    logic signed [37:0] tot_x;
    logic signed [37:0] tot_y;
    logic signed [31:0] add_x;
    logic signed [31:0] add_y;
    logic signed [16:0] ang_sum;
    logic signed [31:0] n_out_x;
    logic signed [31:0] n_out_y;
    logic signed [15:0] n_out_angle;

    assign adv_b   = !r_b_valid || i_ready;
    assign adv_a   = !r_a_valid || adv_b;
    assign o_ready = i_rst_n && !busy && adv_a;

    assign is_inv = (r_a_func == r2dt_pkg::FUNC_POINT_INV);
    assign op_a   = is_inv ? ({r_a_x[31], r_a_x} - {r_offset_x[31], r_offset_x})
                           : {r_a_x[31], r_a_x};
    assign op_b   = is_inv ? ({r_a_y[31], r_a_y} - {r_offset_y[31], r_offset_y})
                           : {r_a_y[31], r_a_y};
    assign c_e    = {r_cos[17], r_cos};
    assign s_e    = is_inv ? -{r_sin[17], r_sin} : {r_sin[17], r_sin};

    assign p_ca  = c_e * op_a;
    assign p_sb  = s_e * op_b;
    assign p_sa  = s_e * op_a;
    assign p_cb  = c_e * op_b;
    assign sum_x = {p_ca[51], p_ca} - {p_sb[51], p_sb} + 53'sd32768;
    assign sum_y = {p_sa[51], p_sa} + {p_cb[51], p_cb} + 53'sd32768;
    assign rd_x  = sum_x[52:16];
    assign rd_y  = sum_y[52:16];

    assign add_x = (r_a_func == r2dt_pkg::FUNC_POINT_FWD) ? r_offset_x : 32'sd0;
    assign add_y = (r_a_func == r2dt_pkg::FUNC_POINT_FWD) ? r_offset_y : 32'sd0;
    assign tot_x = {rd_x[36], rd_x} + {{6{add_x[31]}}, add_x};
    assign tot_y = {rd_y[36], rd_y} + {{6{add_y[31]}}, add_y};

    always_comb begin
        n_out_x     = '0;
        n_out_y     = '0;
        n_out_angle = '0;
        ang_sum     = '0;
        unique case (r_a_func)
            r2dt_pkg::FUNC_POINT_FWD,
            r2dt_pkg::FUNC_DIR_FWD,
            r2dt_pkg::FUNC_POINT_INV: begin
                n_out_x = r2dt_pkg::sat38_32(tot_x);
                n_out_y = r2dt_pkg::sat38_32(tot_y);
            end
            r2dt_pkg::FUNC_ANGLE_ADD: begin
                ang_sum     = {r_a_angle[15], r_a_angle} + {r_angle[15], r_angle};
                n_out_angle = r2dt_pkg::sat17_16(ang_sum);
            end
            r2dt_pkg::FUNC_ANGLE_SUB: begin
                ang_sum     = {r_a_angle[15], r_a_angle} - {r_angle[15], r_angle};
                n_out_angle = r2dt_pkg::sat17_16(ang_sum);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (adv_a) begin
                r_a_valid <= i_valid && o_ready;
            end
            if (adv_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a_func  <= i_func;
            r_a_x     <= i_in_x;
            r_a_y     <= i_in_y;
            r_a_angle <= i_in_angle;
        end
        if (adv_b && r_a_valid) begin
            r_b_x     <= n_out_x;
            r_b_y     <= n_out_y;
            r_b_angle <= n_out_angle;
        end
    end

    assign o_valid     = r_b_valid;
    assign o_out_x     = r_b_x;
    assign o_out_y     = r_b_y;
    assign o_out_angle = r_b_angle;

endmodule
